[hw/rtl/rzc_pkg.sv]
// Shared types and constants for the rotor zero-cross slip timer.
package rzc_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 15;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_DEG    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_DELAY = 2'd3;

  // Serial divider sizing: dividend covers 6*65536 + 65535/2, divisor a 16-bit period
  localparam int DIV_DW = 19;
  localparam int DIV_VW = 16;

  // 6.0 in Q3.16, and degrees in a full turn
  localparam logic [DIV_DW-1:0] SLIP_NUM = 19'd393216;
  localparam logic [DIV_DW-1:0] DEG_FULL = 19'd360;

  typedef enum logic [1:0] {
    OP_SLIP,
    OP_DEG,
    OP_PURE
  } rzc_div_op_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        upd;
    logic        div_start;
    logic        div_latch;
    rzc_div_op_t div_op;
    logic        fin;
    logic        out_load;
  } rzc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enable;
    logic cross_ok;
    logic depth_zero;
    logic div_done;
    logic out_free;
  } rzc_sts_t;

endpackage

[hw/rtl/rzc_ram.sv]
// Generic single-port-write, registered-read RAM.
module rzc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rzc_div.sv]
// Restoring divider, one quotient bit per cycle.
module rzc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rzc_pkg::DIV_DW-1:0]  dividend,
  input  logic [rzc_pkg::DIV_VW-1:0]  divisor,
  output logic                        done,
  output logic [rzc_pkg::DIV_DW-1:0]  quotient
);
  import rzc_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] rem_nxt;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_VW:0]   trial;
  logic [DIV_VW:0]   diff;
  logic              ge;

  assign trial   = {rem_r, quo_r[DIV_DW-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign ge      = (trial >= {1'b0, dvs_r});
  assign rem_nxt = ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_DW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |=> (busy_r || done_r))
    else $error("divider left busy without done");
`endif

endmodule

[hw/rtl/rzc_ctrl.sv]
// Sequencer for one sample: update, up to three divisions, finish, hand off.
module rzc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rzc_pkg::rzc_sts_t sts,
  output rzc_pkg::rzc_cmd_t cmd
);
  import rzc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_SLIP_GO,
    S_SLIP_WAIT,
    S_DEG_GO,
    S_DEG_WAIT,
    S_PURE_GO,
    S_PURE_WAIT,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_op    = OP_SLIP;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = (sts.enable && sts.cross_ok) ? S_SLIP_GO : S_OUT;
      end
      S_SLIP_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SLIP_WAIT;
      end
      S_SLIP_WAIT: begin
        cmd.div_latch = sts.div_done;
        if (sts.div_done) state_nxt = sts.depth_zero ? S_FIN : S_DEG_GO;
      end
      S_DEG_GO: begin
        cmd.div_op    = OP_DEG;
        cmd.div_start = 1'b1;
        state_nxt     = S_DEG_WAIT;
      end
      S_DEG_WAIT: begin
        cmd.div_op    = OP_DEG;
        cmd.div_latch = sts.div_done;
        if (sts.div_done) state_nxt = S_PURE_GO;
      end
      S_PURE_GO: begin
        cmd.div_op    = OP_PURE;
        cmd.div_start = 1'b1;
        state_nxt     = S_PURE_WAIT;
      end
      S_PURE_WAIT: begin
        cmd.div_op    = OP_PURE;
        cmd.div_latch = sts.div_done;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTH
  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_SLIP_WAIT || state_r == S_DEG_WAIT ||
                      state_r == S_PURE_WAIT))
    else $error("divider done outside a wait state");

  a_disabled_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !sts.enable) |=> (state_r == S_OUT))
    else $error("disabled sample did not go straight to output");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.upd, cmd.div_start, cmd.fin, cmd.out_load}))
    else $error("more than one datapath command at once");
`endif

endmodule

[hw/rtl/rzc_dp.sv]
// Datapath: window RAM, moving sum, period counters, divider, result register.
module rzc_dp #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rzc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rzc_pkg::CFG_DW-1:0]     cfg_data,
  input  logic                           in_enable,
  input  logic signed [15:0]             in_sample,
  input  rzc_pkg::rzc_cmd_t              cmd,
  output rzc_pkg::rzc_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_zero_cross,
  output logic                           out_fire,
  output logic                           out_slip_valid,
  output logic [15:0]                    out_slip,
  output logic [15:0]                    out_period_ticks
);
  import rzc_pkg::*;

  localparam int AW       = $clog2(WINDOW_LEN);
  localparam int SW       = 16 + AW;
  localparam int HALF_WIN = WINDOW_LEN / 2;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // configuration
  logic [14:0] max_period_r;
  logic [14:0] min_period_r;
  logic [8:0]  depth_r;
  logic [7:0]  fdel_r;

  // tick state
  logic [WINDOW_LEN-1:0] vld_r;
  logic [AW-1:0]         wpos_r;
  logic signed [SW-1:0]  sum_r;
  logic [15:0]           pc_r;
  logic [15:0]           pos_r;
  logic [15:0]           neg_r;
  logic                  neg_seen_r;
  logic                  waiting_r;
  logic [15:0]           wait_r;
  logic [15:0]           target_r;
  logic [15:0]           slip_r;

  // per-sample working registers
  logic                  en_r;
  logic signed [15:0]    smp_r;
  logic                  rd_vld_r;
  logic [15:0]           p_r;
  logic [8:0]            deg_r;
  logic                  res_zc_r;
  logic                  res_fire_r;
  logic                  res_valid_r;
  logic [15:0]           res_period_r;

  // result register
  logic                  out_valid_r;
  logic                  out_zc_r;
  logic                  out_fire_r;
  logic                  out_sv_r;
  logic [15:0]           out_slip_r;
  logic [15:0]           out_period_r;

  // window RAM
  logic [15:0] ram_rd;

  rzc_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_LEN)
  ) u_win (
    .clk   (clk),
    .we    (cmd.upd && en_r),
    .waddr (wpos_r),
    .wdata (smp_r),
    .re    (cmd.capture),
    .raddr (wpos_r),
    .rdata (ram_rd)
  );

  // divider
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_VW-1:0] div_dvs;
  logic              div_done;
  logic [DIV_DW-1:0] div_q;
  logic [8:0]        deg_div;

  assign deg_div = (deg_r == 9'd0) ? 9'd1 : deg_r;

  always_comb begin
    case (cmd.div_op)
      OP_DEG: begin
        div_dvd = DEG_FULL;
        div_dvs = {7'd0, depth_r};
      end
      OP_PURE: begin
        div_dvd = {3'd0, p_r};
        div_dvs = {7'd0, deg_div};
      end
      default: begin
        div_dvd = SLIP_NUM + {4'd0, p_r[15:1]};
        div_dvs = p_r;
      end
    endcase
  end

  rzc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // tick update
  logic                 ovl;
  logic [15:0]          pc0, pos0, neg0, wt0, pc1, pos1, neg1, winc, wt1;
  logic                 wtg0, wtg1, fire1;
  logic signed [15:0]   old_smp;
  logic signed [SW-1:0] sum_nxt;
  logic                 nonneg, xing, len_ok;
  logic [13:0]          half;

  always_comb begin
    ovl  = (pc_r > {1'b0, max_period_r});
    pc0  = ovl ? 16'd0 : pc_r;
    pos0 = ovl ? 16'd0 : pos_r;
    neg0 = ovl ? 16'd0 : neg_r;
    wtg0 = ovl ? 1'b0  : waiting_r;
    wt0  = ovl ? 16'd0 : wait_r;
    pc1  = sat_inc(pc0);

    old_smp = rd_vld_r ? $signed(ram_rd) : 16'sd0;
    sum_nxt = sum_r - {{(SW-16){old_smp[15]}}, old_smp} + {{(SW-16){smp_r[15]}}, smp_r};

    winc  = sat_inc(wt0);
    fire1 = 1'b0;
    wtg1  = wtg0;
    wt1   = wt0;
    if (wtg0) begin
      if (winc >= target_r) begin
        fire1 = 1'b1;
        wtg1  = 1'b0;
        wt1   = 16'd0;
      end else begin
        wt1 = winc;
      end
    end

    nonneg = !sum_nxt[SW-1];
    pos1   = nonneg ? sat_inc(pos0) : pos0;
    neg1   = nonneg ? neg0 : sat_inc(neg0);
    xing   = nonneg && (sum_nxt != '0) && neg_seen_r;
    half   = min_period_r[14:1];
    len_ok = (pc1 > {1'b0, min_period_r}) && (pos1 > {2'd0, half}) &&
             (neg1 > {2'd0, half});
  end

  // firing target from the pure delay
  logic [15:0] pure_dly;
  logic [17:0] tgt;
  logic        tgt_pos;

  assign pure_dly = (depth_r == 9'd0) ? 16'd0 : div_q[15:0];
  assign tgt      = {2'd0, pure_dly} - 18'(HALF_WIN) - {10'd0, fdel_r};
  assign tgt_pos  = !tgt[17] && (tgt != 18'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_period_r <= 15'd600;
      min_period_r <= 15'd20;
      depth_r      <= 9'd30;
      fdel_r       <= 8'd4;
      vld_r        <= '0;
      wpos_r       <= '0;
      sum_r        <= '0;
      pc_r         <= '0;
      pos_r        <= '0;
      neg_r        <= '0;
      neg_seen_r   <= 1'b0;
      waiting_r    <= 1'b0;
      wait_r       <= '0;
      target_r     <= '0;
      slip_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_PERIOD:   max_period_r <= cfg_data;
          REG_MIN_PERIOD:   min_period_r <= cfg_data;
          REG_DEPTH_DEG:    depth_r      <= cfg_data[8:0];
          REG_FILTER_DELAY: fdel_r       <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (cmd.capture) begin
        en_r         <= in_enable;
        smp_r        <= in_sample;
        rd_vld_r     <= vld_r[wpos_r];
        res_zc_r     <= 1'b0;
        res_fire_r   <= 1'b0;
        res_valid_r  <= 1'b0;
        res_period_r <= '0;
      end

      if (cmd.upd && en_r) begin
        vld_r[wpos_r] <= 1'b1;
        wpos_r        <= (wpos_r == AW'(WINDOW_LEN - 1)) ? '0 : wpos_r + 1'b1;
        sum_r         <= sum_nxt;
        res_fire_r    <= fire1;
        if (xing) begin
          p_r          <= pc1;
          res_zc_r     <= 1'b1;
          res_valid_r  <= len_ok;
          res_period_r <= pc1;
          neg_seen_r   <= 1'b0;
          pc_r         <= '0;
          pos_r        <= '0;
          neg_r        <= '0;
          waiting_r    <= len_ok ? wtg1 : 1'b0;
          wait_r       <= len_ok ? wt1  : 16'd0;
        end else begin
          neg_seen_r   <= neg_seen_r | !nonneg;
          pc_r         <= pc1;
          pos_r        <= pos1;
          neg_r        <= neg1;
          waiting_r    <= wtg1;
          wait_r       <= wt1;
        end
      end

      if (cmd.div_latch && cmd.div_op == OP_SLIP) begin
        slip_r <= (div_q[18:16] != 3'd0) ? 16'hFFFF : div_q[15:0];
      end
      if (cmd.div_latch && cmd.div_op == OP_DEG) begin
        deg_r <= div_q[8:0];
      end

      if (cmd.fin) begin
        if (tgt_pos) begin
          target_r  <= tgt[15:0];
          wait_r    <= '0;
          waiting_r <= 1'b1;
        end else begin
          target_r   <= '0;
          waiting_r  <= 1'b0;
          res_fire_r <= 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid_r  <= 1'b1;
        out_zc_r     <= res_zc_r;
        out_fire_r   <= res_fire_r;
        out_sv_r     <= res_valid_r;
        out_slip_r   <= slip_r;
        out_period_r <= res_period_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.enable     = en_r;
    sts.cross_ok   = xing && len_ok;
    sts.depth_zero = (depth_r == 9'd0);
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_zero_cross   = out_zc_r;
  assign out_fire         = out_fire_r;
  assign out_slip_valid   = out_sv_r;
  assign out_slip         = out_slip_r;
  assign out_period_ticks = out_period_r;

endmodule

[hw/rtl/rotor_zero_cross_slip_timer.sv]
// Top level of the rotor zero-cross slip timer: controller plus datapath.
//
//  channel  direction  handshake             word
//  in_      input      in_valid / in_stall   in_enable, in_sample
//  out_     output     out_valid / out_stall out_zero_cross, out_fire, out_slip_valid,
//                                            out_slip, out_period_ticks
//  cfg_     input      cfg_we                cfg_index, cfg_data (write only)
//
// One word in, one word out. A disabled sample or an ordinary tick goes from the update
// step straight to the output register; a crossing that passes the length checks first
// runs three back-to-back 19-step divisions on the one shared serial divider
// (slip, 360/depth_deg, period/divisor). With depth_deg at zero the last two are
// skipped.
// A new word is taken only once the previous result sits in the output register,
// so a stalled output holds at most one finished word while the next is accepted.
// rst_n is synchronous, active low; the window reads as zeros until each entry is
// written (per-entry valid bits), and the registers return to their defaults.
module rotor_zero_cross_slip_timer #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [rzc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rzc_pkg::CFG_DW-1:0]    cfg_data,
  // sample words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_enable,
  input  logic signed [15:0]            in_sample,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_zero_cross,
  output logic                          out_fire,
  output logic                          out_slip_valid,
  output logic [15:0]                   out_slip,
  output logic [15:0]                   out_period_ticks
);
  import rzc_pkg::*;

  rzc_cmd_t cmd;
  rzc_sts_t sts;

  // Sequencing only; no payload passes through the controller.
  rzc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // All state but the controller's sequence lives here, including the result register.
  rzc_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_enable        (in_enable),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_zero_cross   (out_zero_cross),
    .out_fire         (out_fire),
    .out_slip_valid   (out_slip_valid),
    .out_slip         (out_slip),
    .out_period_ticks (out_period_ticks)
  );

endmodule

[test/rotor_zero_cross_slip_timer_tb.sv]
// Self-checking testbench for the rotor zero-cross slip timer: directed table, then random waves.
module rotor_zero_cross_slip_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rzc_pkg::*;

  localparam int WIN_LEN       = 8;
  localparam int CYCLE_LIMIT   = 600000;  // watchdog bound on the whole run
  localparam int SETTLE_CYCLES = 100;     // longer than a full three-division crossing
  localparam int PHASE_WORDS   = 90;      // enabled words per random register setting
  localparam int N_PHASES      = 8;
  localparam int Q16_SIX       = 6 * 65536;
  localparam int FULL_TURN     = 360;

  // one result word, packed in port order
  typedef struct packed {
    logic        zero_cross;
    logic        fire;
    logic        slip_valid;
    logic [15:0] slip;
    logic [15:0] period_ticks;
  } rotor_word_t;

  localparam rotor_word_t ZERO_WORD = '0;

  // one line of the directed table: either a register write or a run of sample words
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [14:0]          reg_val;
    logic                 en;
    logic [15:0]          smp;
    logic [5:0]           reps;
    logic                 typed;   // want holds a hand-read result
    rotor_word_t          want;
  } plan_row_t;

  localparam int N_ROWS = 22;
  localparam plan_row_t PLAN [N_ROWS] = '{
    // straight out of reset: a disabled word, then a swing that crosses too early
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b0, 16'h7FFF, 6'd1, 1'b1, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h8000, 6'd1, 1'b1, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h7FFF, 6'd1, 1'b1, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h7FFF, 6'd1, 1'b1,
      {1'b1, 1'b0, 1'b0, 16'd0, 16'd3}},
    // no length limit, zero depth, no filter: two-tick period saturates slip, fires at once
    '{1'b1, REG_MIN_PERIOD,   15'd0, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_DEPTH_DEG,    15'd0, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_FILTER_DELAY, 15'd0, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h8000, 6'd1, 1'b1, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h7FFF, 6'd1, 1'b1,
      {1'b1, 1'b1, 1'b1, 16'd65535, 16'd2}},
    // widest period, full-turn depth: waits close to a whole period
    '{1'b1, REG_MAX_PERIOD,   15'd32767, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_MIN_PERIOD,   15'd2,     1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_DEPTH_DEG,    15'd360,   1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'hB1E0, 6'd5, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h4E20, 6'd4, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'hB1E0, 6'd4, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h4E20, 6'd4, 1'b0, ZERO_WORD},
    // zero period limit, depth past a full turn, longest filter delay
    '{1'b1, REG_MAX_PERIOD,   15'd0,   1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_DEPTH_DEG,    15'd511, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b1, REG_FILTER_DELAY, 15'd255, 1'b0, 16'h0, 6'd0, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h0000, 6'd1, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'hFFFF, 6'd1, 1'b0, ZERO_WORD},
    '{1'b0, REG_MAX_PERIOD, 15'd0, 1'b1, 16'h0001, 6'd1, 1'b0, ZERO_WORD}
  };

  // random register settings; the last one is drawn at run time
  // half-wave lengths bound the generated waves for each setting
  localparam int PH_MAX  [N_PHASES] = '{600, 60, 32767, 1, 200, 80, 0, 0};
  localparam int PH_MIN  [N_PHASES] = '{20, 6, 0, 2, 32767, 8, 0, 0};
  localparam int PH_DEPTH[N_PHASES] = '{30, 180, 0, 360, 1, 360, 511, 0};
  localparam int PH_FILT [N_PHASES] = '{4, 0, 255, 0, 8, 0, 3, 0};
  localparam int PH_HLO  [N_PHASES] = '{12, 3, 1, 2, 4, 5, 1, 2};
  localparam int PH_HHI  [N_PHASES] = '{55, 35, 12, 10, 30, 15, 8, 25};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_enable;
  logic signed [15:0]   in_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_zero_cross;
  logic                 out_fire;
  logic                 out_slip_valid;
  logic [15:0]          out_slip;
  logic [15:0]          out_period_ticks;

  rotor_zero_cross_slip_timer #(
    .WINDOW_LEN(WIN_LEN)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_enable       (in_enable),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_zero_cross  (out_zero_cross),
    .out_fire        (out_fire),
    .out_slip_valid  (out_slip_valid),
    .out_slip        (out_slip),
    .out_period_ticks(out_period_ticks)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Timer model: own copy of the smoothing window, counters and firing wait
  // ---------------------------------------------------------------------------
  int          smooth_win [WIN_LEN];
  int          smooth_sum;
  int          win_ptr;
  int          per_cnt, pos_cnt, neg_cnt;
  bit          saw_neg;
  bit          fire_armed;
  int          fire_wait, fire_target;
  logic [15:0] slip_q16;
  // register copies
  int          lim_max_period, lim_min_period, fire_depth, filt_delay;

  rotor_word_t expected_words [$];   // predicted words, oldest first

  // bookkeeping
  int  cycle_count;
  int  mismatches;
  int  words_sent, enabled_words, words_seen;
  int  crossings_seen, fires_seen, slip_updates;
  int  settings_used;
  bit  calm;          // no idling on either side while set
  int  stall_left;
  int  stall_len;

  function automatic int sat_up(input int v);
    return (v >= 65535) ? 65535 : v + 1;
  endfunction

  function automatic void drop_period();
    per_cnt    = 0;
    pos_cnt    = 0;
    neg_cnt    = 0;
    fire_armed = 0;
    fire_wait  = 0;
  endfunction

  // advance the timer model by one sample word and return the word it should produce
  function automatic rotor_word_t advance_rotor(input logic en, input logic signed [15:0] smp);
    rotor_word_t w;
    int half, p, q, pure_ticks, divisor, tgt;
    w = ZERO_WORD;
    if (en) begin
      if (per_cnt > lim_max_period) drop_period();
      per_cnt = sat_up(per_cnt);

      smooth_sum = smooth_sum - smooth_win[win_ptr] + int'(smp);
      smooth_win[win_ptr] = int'(smp);
      win_ptr = (win_ptr + 1) % WIN_LEN;

      if (fire_armed) begin
        fire_wait = sat_up(fire_wait);
        if (fire_wait >= fire_target) begin
          w.fire     = 1'b1;
          fire_armed = 0;
          fire_wait  = 0;
        end
      end

      if (smooth_sum >= 0) begin
        pos_cnt = sat_up(pos_cnt);
      end else begin
        saw_neg = 1;
        neg_cnt = sat_up(neg_cnt);
      end

      // minus-to-plus crossing of the moving sum
      if (smooth_sum > 0 && saw_neg) begin
        half = lim_min_period / 2;
        saw_neg = 0;
        w.zero_cross   = 1'b1;
        w.period_ticks = per_cnt[15:0];
        p = per_cnt;
        if (p > lim_min_period && pos_cnt > half && neg_cnt > half) begin
          q = (Q16_SIX + p / 2) / p;
          slip_q16 = (q > 65535) ? 16'hFFFF : q[15:0];
          w.slip_valid = 1'b1;
          if (fire_depth == 0) begin
            pure_ticks = 0;
          end else begin
            divisor = FULL_TURN / fire_depth;
            if (divisor == 0) divisor = 1;
            pure_ticks = p / divisor;
          end
          tgt = pure_ticks - WIN_LEN / 2 - filt_delay;
          if (tgt <= 0) begin
            fire_target = 0;
            w.fire      = 1'b1;
            fire_armed  = 0;
          end else begin
            fire_target = tgt & 16'hFFFF;
            fire_wait   = 0;
            fire_armed  = 1;
          end
        end else begin
          drop_period();   // short wave
        end
        per_cnt = 0;
        pos_cnt = 0;
        neg_cnt = 0;
      end
    end
    w.slip = slip_q16;
    return w;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic en, input logic [15:0] smp,
                           input logic typed, input rotor_word_t want);
    rotor_word_t w;
    int gap;
    in_valid  <= 1'b1;
    in_enable <= en;
    in_sample <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    w = advance_rotor(en, smp);
    expected_words.push_back(typed ? want : w);
    words_sent++;
    if (en) enabled_words++;
    @(negedge clk);
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender holds off until every predicted word is back, then lets the divider settle
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MAX_PERIOD:   lim_max_period = int'(val);
      REG_MIN_PERIOD:   lim_min_period = int'(val);
      REG_DEPTH_DEG:    fire_depth     = int'(val[8:0]);
      REG_FILTER_DELAY: filt_delay     = int'(val[7:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one half-wave with random amplitude and some ripple; a few words disabled
  task automatic emit_half(input bit neg, input int len);
    int amp, mag, v, i;
    logic en;
    amp = $urandom_range(1, 32767);
    for (i = 0; i < len; i++) begin
      mag = amp - $urandom_range(0, amp / 4);
      if (!neg)                                          v = mag;
      else if (mag == 32767 && $urandom_range(0, 1) != 0) v = -32768;
      else                                               v = -mag;
      en = ($urandom_range(0, 19) != 0);
      send_word(en, v[15:0], 1'b0, ZERO_WORD);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, changed on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_len = pick_idle();
      if (stall_len > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_len - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rotor_word_t got, want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_zero_cross, out_fire, out_slip_valid, out_slip, out_period_ticks};
      words_seen++;
      crossings_seen += got.zero_cross;
      fires_seen     += got.fire;
      slip_updates   += got.slip_valid;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: result word with nothing pending: zc=%0b fire=%0b sv=%0b slip=%0d per=%0d",
                   cycle_count, got.zero_cross, got.fire, got.slip_valid, got.slip,
                   got.period_ticks);
      end else begin
        want = expected_words.pop_front();
        if (got.zero_cross !== want.zero_cross || got.fire !== want.fire ||
            got.slip_valid !== want.slip_valid || got.slip !== want.slip ||
            got.period_ticks !== want.period_ticks) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d word %0d: want zc=%0b fire=%0b sv=%0b slip=%0d per=%0d, got zc=%0b fire=%0b sv=%0b slip=%0d per=%0d",
                     cycle_count, words_seen, want.zero_cross, want.fire, want.slip_valid,
                     want.slip, want.period_ticks, got.zero_cross, got.fire, got.slip_valid,
                     got.slip, got.period_ticks);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               expected_words.size());
      $display("[rotor_zero_cross_slip_timer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int r, ph, start_cnt, kind;
    logic [14:0] v_max, v_min, v_depth, v_filt;
    logic [15:0] noise;

    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_enable = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    calm      = 1'b0;
    stall_left = 0;

    // model state after reset
    for (int i = 0; i < WIN_LEN; i++) smooth_win[i] = 0;
    smooth_sum = 0; win_ptr = 0;
    per_cnt = 0; pos_cnt = 0; neg_cnt = 0;
    saw_neg = 0; fire_armed = 0; fire_wait = 0; fire_target = 0;
    slip_q16 = '0;
    lim_max_period = 600; lim_min_period = 20; fire_depth = 30; filt_delay = 4;
    settings_used = 1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (r = 0; r < N_ROWS; r++) begin
      if (PLAN[r].is_reg) begin
        write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      end else begin
        repeat (PLAN[r].reps) send_word(PLAN[r].en, PLAN[r].smp, PLAN[r].typed, PLAN[r].want);
      end
    end
    settings_used += 2;

    // random waves, one register setting per phase
    for (ph = 0; ph < N_PHASES; ph++) begin
      calm = 1'b0;
      if (ph == N_PHASES - 1) begin
        // random setting; narrow registers get junk in the unused upper bits
        v_max   = 15'($urandom_range(20, 400));
        v_min   = 15'($urandom_range(0, 40));
        v_depth = {6'($urandom_range(0, 63)), 9'($urandom_range(0, 511))};
        v_filt  = {7'($urandom_range(0, 127)), 8'($urandom_range(0, 40))};
      end else begin
        v_max   = 15'(PH_MAX[ph]);
        v_min   = 15'(PH_MIN[ph]);
        v_depth = 15'(PH_DEPTH[ph]);
        v_filt  = 15'(PH_FILT[ph]);
      end
      write_reg(REG_MAX_PERIOD,   v_max);
      write_reg(REG_MIN_PERIOD,   v_min);
      write_reg(REG_DEPTH_DEG,    v_depth);
      write_reg(REG_FILTER_DELAY, v_filt);
      settings_used++;
      calm = (ph % 3 == 2);   // every third setting runs without any gaps

      start_cnt = enabled_words;
      while (enabled_words - start_cnt < PHASE_WORDS) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // a full wave, negative half first so the crossing is armed
          emit_half(1'b1, $urandom_range(PH_HLO[ph], PH_HHI[ph]));
          emit_half(1'b0, $urandom_range(PH_HLO[ph], PH_HHI[ph]));
        end else if (kind < 90) begin
          // raw noise, any bit pattern, enable random
          repeat ($urandom_range(1, 6)) begin
            noise = 16'($urandom());
            send_word(1'($urandom_range(0, 1)), noise, 1'b0, ZERO_WORD);
          end
        end else begin
          // broken wave: a stub half of either sign
          emit_half(1'($urandom_range(0, 1)), $urandom_range(1, 2));
        end
      end
    end

    calm = 1'b0;
    drain_block();

    $display("ran %0d sample words (%0d enabled) over %0d register settings",
             words_sent, enabled_words, settings_used);
    $display("saw %0d crossings, %0d slip updates, %0d fire events, %0d mismatches",
             crossings_seen, slip_updates, fires_seen, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[rotor_zero_cross_slip_timer] OK");
    end else begin
      $display("[rotor_zero_cross_slip_timer] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rzc_pkg.sv
hw/rtl/rzc_ram.sv
hw/rtl/rzc_div.sv
hw/rtl/rzc_ctrl.sv
hw/rtl/rzc_dp.sv
hw/rtl/rotor_zero_cross_slip_timer.sv
test/rotor_zero_cross_slip_timer_tb.sv
